// ===== sv/ktls_pkg.sv =====
// ----------------------------------------------------------------------------
// ktls_pkg
// Shared types and constants for the keyframe track sampler.
// ----------------------------------------------------------------------------
package ktls_pkg;
    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = 7;
    localparam int ENTRY_W  = 128;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic        start;
        logic [63:0] mag_num;
        logic [31:0] dt;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;
endpackage

// ===== sv/keyframe_track_lerp_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// keyframe_track_lerp_sampler_unit
// Sorted keyframe table with linear interpolation sampling.
// ----------------------------------------------------------------------------
// Insert: keys at or after the new moment move up one slot; then the key is written.
// Sample: walks to the bracketing keys, then x, y, z in turn use the shared divider.
// One request at a time; s_tready is low while a request is processed.
// A result waits in the output register; the next request enters the cycle after it.
// Reset clears the key count and control; table contents stay undefined.
module keyframe_track_lerp_sampler_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // moment, value_x, value_y, value_z
    input  logic         s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata   // result_x, result_y, result_z, status, keys_held
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_IRD   = 11'b00000000010,
        S_IWT   = 11'b00000000100,
        S_ICHK  = 11'b00000001000,
        S_SRD   = 11'b00000010000,
        S_SWT   = 11'b00000100000,
        S_SCHK  = 11'b00001000000,
        S_PRV   = 11'b00010000000,
        S_PWT   = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    localparam int IW = ktls_pkg::IDX_W;
    localparam int CW = ktls_pkg::CNT_W;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] status_reg, status_next;
    logic [127:0] req_reg, req_next;
    logic [127:0] hi_reg, hi_next;
    logic [127:0] lo_reg, lo_next;
    logic [95:0]  res_reg, res_next;
    logic         mvalid_reg, mvalid_next;
    logic         neg_reg, neg_next;

    logic         we;
    logic [IW-1:0] waddr, raddr;
    logic [127:0] wdata, rdata;
    ktls_pkg::div_req_t dreq;
    ktls_pkg::div_rsp_t drsp;

    logic [31:0] tick, t1, dt;
    logic signed [32:0] off;
    logic [31:0] mo;
    logic signed [32:0] va, vb, diff;
    logic [31:0] md;
    logic [63:0] prod;
    logic [33:0] q_sat;
    logic signed [34:0] sum;
    logic [31:0] sat;

    ktls_ram #(.DEPTH(ktls_pkg::MAX_KEYS), .WIDTH(ktls_pkg::ENTRY_W), .ADDR_W(IW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    ktls_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign tick = req_reg[31:0];
    assign t1   = lo_reg[31:0];
    assign dt   = hi_reg[31:0] - lo_reg[31:0];

    always_comb
    begin
        off  = $signed({1'b0, tick}) - $signed({1'b0, t1});
        mo   = off[32] ? 32'(-off) : off[31:0];
        unique case (comp_reg)
            2'd0:    begin va = $signed({lo_reg[63], lo_reg[63:32]});
                           vb = $signed({hi_reg[63], hi_reg[63:32]}); end
            2'd1:    begin va = $signed({lo_reg[95], lo_reg[95:64]});
                           vb = $signed({hi_reg[95], hi_reg[95:64]}); end
            default: begin va = $signed({lo_reg[127], lo_reg[127:96]});
                           vb = $signed({hi_reg[127], hi_reg[127:96]}); end
        endcase
        diff = vb - va;
        md   = diff[32] ? 32'(-diff) : diff[31:0];
        prod = mo * md;
        q_sat = (drsp.quot > 64'h2_0000_0000) ? 34'h2_0000_0000 : drsp.quot[33:0];
        sum  = neg_reg ? (35'(va) - $signed({1'b0, q_sat}))
                       : (35'(va) + $signed({1'b0, q_sat}));
        if (sum > 35'sd2147483647)
            sat = 32'h7fff_ffff;
        else if (sum < -35'sd2147483648)
            sat = 32'h8000_0000;
        else
            sat = sum[31:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        comp_next   = comp_reg;
        status_next = status_reg;
        req_next    = req_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg;
        neg_next    = neg_reg;
        we    = 1'b0;
        waddr = ptr_reg[IW-1:0];
        wdata = rdata;
        raddr = ptr_reg[IW-1:0];
        dreq.start   = 1'b0;
        dreq.mag_num = prod + {33'b0, dt[31:1]};
        dreq.dt      = dt;

        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && !mvalid_reg)
                begin
                    req_next    = s_tdata;
                    res_next    = '0;
                    status_next = ktls_pkg::ST_OK;
                    ptr_next    = count_reg;
                    if (s_tuser == ktls_pkg::KIND_INSERT)
                    begin
                        if (count_reg >= CW'(ktls_pkg::MAX_KEYS))
                        begin
                            status_next = ktls_pkg::ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                            state_next = S_IRD;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ktls_pkg::ST_EMPTY;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        ptr_next   = (count_reg == CW'(1)) ? '0 : CW'(1);
                        state_next = S_SRD;
                    end
                end
            end
            S_IRD:
            begin
                if (ptr_reg == '0)
                begin
                    we = 1'b1; wdata = req_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    raddr = IW'(ptr_reg - CW'(1));
                    state_next = S_IWT;
                end
            end
            S_IWT:
            begin
                raddr = IW'(ptr_reg - CW'(1));
                state_next = S_ICHK;
            end
            S_ICHK:
            begin
                if (rdata[31:0] >= req_reg[31:0])
                begin
                    we = 1'b1;
                    ptr_next = ptr_reg - CW'(1);
                    state_next = S_IRD;
                end
                else
                begin
                    we = 1'b1; wdata = req_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_SRD:
                state_next = S_SWT;
            S_SWT:
                state_next = S_SCHK;
            S_SCHK:
            begin
                hi_next = rdata;
                if (count_reg == CW'(1))
                begin
                    res_next   = rdata[127:32];
                    state_next = S_OUT;
                end
                else if (ptr_reg < count_reg - CW'(1) && rdata[31:0] <= tick)
                begin
                    ptr_next   = ptr_reg + CW'(1);
                    state_next = S_SRD;
                end
                else
                begin
                    ptr_next   = ptr_reg - CW'(1);
                    state_next = S_PRV;
                end
            end
            S_PRV:
                state_next = S_PWT;
            S_PWT:
            begin
                lo_next = rdata;
                comp_next = 2'd0;
                if (hi_reg[31:0] == rdata[31:0])
                begin
                    res_next    = rdata[127:32];
                    status_next = ktls_pkg::ST_ZERO;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (ptr_reg != '1 && !drsp.done && comp_reg != 2'd3)
                begin
                    dreq.start = 1'b1;
                    neg_next   = off[32] ^ diff[32];
                    ptr_next   = '1;
                end
                else if (drsp.done)
                begin
                    unique case (comp_reg)
                        2'd0:    res_next[31:0]  = sat;
                        2'd1:    res_next[63:32] = sat;
                        default: res_next[95:64] = sat;
                    endcase
                    ptr_next = '0;
                    if (comp_reg == 2'd2)
                        state_next = S_OUT;
                    else
                        comp_next = comp_reg + 2'd1;
                end
            end
            S_OUT:
            begin
                mvalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        comp_reg   <= comp_next;
        status_reg <= status_next;
        req_reg    <= req_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        res_reg    <= res_next;
        neg_reg    <= neg_next;
    end

    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'b0, count_reg, status_reg, res_reg};

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= CW'(ktls_pkg::MAX_KEYS);
    endproperty
    assert property (p_count_bound) else $error("key count above capacity");

    property p_count_step;
        @(posedge clk) disable iff (!rst_n)
            (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1));
    endproperty
    assert property (p_count_step) else $error("key count jumped");

    property p_full_status;
        @(posedge clk) disable iff (!rst_n)
            (s_tvalid && s_tready && s_tuser == ktls_pkg::KIND_INSERT
             && count_reg == CW'(ktls_pkg::MAX_KEYS)) |=> ##1 (status_reg == ktls_pkg::ST_FULL);
    endproperty
    assert property (p_full_status) else $error("full insert not flagged");

    property p_ready_out;
        @(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready;
    endproperty
    assert property (p_ready_out) else $error("request taken while result waits");
endmodule

// ===== sv/ktls_ram.sv =====
// ----------------------------------------------------------------------------
// ktls_ram
// Key table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ktls_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 128,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/ktls_div.sv =====
// ----------------------------------------------------------------------------
// ktls_div
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module ktls_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ktls_pkg::div_req_t req,
    output ktls_pkg::div_rsp_t rsp
);
    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dt_reg, dt_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dt_next   = dt_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            quot_next = req.mag_num;
            rem_next  = '0;
            dt_next   = req.dt;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quot_reg[63]} - {2'b0, dt_reg};
            if (!trial[33])
            begin
                rem_next  = trial[32:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[31:0], quot_reg[63]};
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dt_reg   <= dt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

// ===== test/tb_keyframe_track_lerp_sampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_track_lerp_sampler_unit
// Self-checking bench: drives insert and sample requests into the keyframe
// sampler and checks every result against a behavioral track model.
// ----------------------------------------------------------------------------
module tb_keyframe_track_lerp_sampler_unit;
    typedef struct packed {
        logic        kind;
        logic [31:0] moment;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } track_req_t;

    typedef struct packed {
        logic [6:0]  keys_held;
        logic [1:0]  status;
        logic [31:0] rz;
        logic [31:0] ry;
        logic [31:0] rx;
    } track_rsp_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;

    keyframe_track_lerp_sampler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [31:0] trk_time [ktls_pkg::MAX_KEYS];
    logic [31:0] trk_x [ktls_pkg::MAX_KEYS];
    logic [31:0] trk_y [ktls_pkg::MAX_KEYS];
    logic [31:0] trk_z [ktls_pkg::MAX_KEYS];
    int          trk_count = 0;

    track_req_t  pending_reqs[$];
    track_rsp_t  expected_samples[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_seq = 0;
    int          hold_seen;
    int          hold_left;
    int          errors = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          sample_count = 0;
    int          full_count = 0;
    int          zero_count = 0;
    int          empty_count = 0;

    function automatic logic [31:0] lerp_one(logic [31:0] v1, logic [31:0] v2,
                                             logic [31:0] tick, logic [31:0] t1,
                                             logic [31:0] dt);
        longint     a;
        longint     b;
        longint     off;
        longint     diff;
        bit         neg;
        logic [63:0] mo;
        logic [63:0] md;
        logic [127:0] prod;
        logic [127:0] q;
        longint     r;
        a = longint'($signed(v1));
        b = longint'($signed(v2));
        off = longint'({32'd0, tick}) - longint'({32'd0, t1});
        diff = b - a;
        neg = (off < 0) != (diff < 0);
        mo = (off < 0) ? -off : off;
        md = (diff < 0) ? -diff : diff;
        prod = 128'(mo) * 128'(md);
        q = (prod + 128'(dt >> 1)) / 128'(dt);
        if (q > 128'h2_0000_0000)
            q = 128'h2_0000_0000;
        r = neg ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic track_rsp_t track_step(track_req_t req);
        track_rsp_t  rsp;
        int          p;
        int          j;
        logic [31:0] dt;
        rsp = '0;
        if (req.kind == ktls_pkg::KIND_INSERT) begin
            if (trk_count >= ktls_pkg::MAX_KEYS) begin
                rsp.status = ktls_pkg::ST_FULL;
                full_count++;
            end else begin
                p = trk_count;
                while (p > 0 && trk_time[p-1] >= req.moment) begin
                    trk_time[p] = trk_time[p-1];
                    trk_x[p] = trk_x[p-1];
                    trk_y[p] = trk_y[p-1];
                    trk_z[p] = trk_z[p-1];
                    p--;
                end
                trk_time[p] = req.moment;
                trk_x[p] = req.vx;
                trk_y[p] = req.vy;
                trk_z[p] = req.vz;
                trk_count++;
            end
        end else if (trk_count == 0) begin
            rsp.status = ktls_pkg::ST_EMPTY;
            empty_count++;
        end else if (trk_count == 1) begin
            rsp.rx = trk_x[0];
            rsp.ry = trk_y[0];
            rsp.rz = trk_z[0];
            sample_count++;
        end else begin
            j = 1;
            while (j < trk_count - 1 && trk_time[j] <= req.moment)
                j++;
            dt = trk_time[j] - trk_time[j-1];
            if (dt == 0) begin
                rsp.rx = trk_x[j-1];
                rsp.ry = trk_y[j-1];
                rsp.rz = trk_z[j-1];
                rsp.status = ktls_pkg::ST_ZERO;
                zero_count++;
            end else begin
                rsp.rx = lerp_one(trk_x[j-1], trk_x[j], req.moment, trk_time[j-1], dt);
                rsp.ry = lerp_one(trk_y[j-1], trk_y[j], req.moment, trk_time[j-1], dt);
                rsp.rz = lerp_one(trk_z[j-1], trk_z[j], req.moment, trk_time[j-1], dt);
                sample_count++;
            end
        end
        rsp.keys_held = 7'(trk_count);
        return rsp;
    endfunction

    function automatic logic [31:0] rand_value(int style);
        case (style)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic track_req_t make_req(logic kind, logic [31:0] moment,
                                            logic [31:0] vx, logic [31:0] vy,
                                            logic [31:0] vz);
        track_req_t r;
        r.kind = kind;
        r.moment = moment;
        r.vx = vx;
        r.vy = vy;
        r.vz = vz;
        return r;
    endfunction

    function automatic void add_req(track_req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic logic [31:0] rand_moment(int span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($urandom_range(0, span));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                track_req_t r;
                r = pending_reqs.pop_front();
                expected_samples = {expected_samples, track_step(r)};
                s_tvalid <= 1'b1;
                s_tuser  <= r.kind;
                s_tdata  <= {r.vz, r.vy, r.vx, r.moment};
                sent_count++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_seq;
            hold_left <= 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= 2000;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            track_rsp_t got;
            track_rsp_t want;
            got = m_tdata[104:0];
            if (expected_samples.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                checked_count++;
                if (got.rx !== want.rx) begin
                    $error("result_x expected %h got %h", want.rx, got.rx);
                    errors++;
                end
                if (got.ry !== want.ry) begin
                    $error("result_y expected %h got %h", want.ry, got.ry);
                    errors++;
                end
                if (got.rz !== want.rz) begin
                    $error("result_z expected %h got %h", want.rz, got.rz);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.keys_held !== want.keys_held) begin
                    $error("keys_held expected %0d got %0d", want.keys_held, got.keys_held);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_samples.size() > 0 || s_tvalid)
            @(posedge clk);
    endtask

    // queue random inserts, then samples over the span; a full table drops inserts
    task automatic queue_track_session(int keys, int samples, int span);
        int k;
        int style;
        style = $urandom_range(0, 3);
        for (k = 0; k < keys; k++) begin
            logic [31:0] m;
            m = ($urandom_range(0, 5) == 0 && k > 0) ? pending_reqs[$].moment
                                                       : rand_moment(span);
            add_req(make_req(ktls_pkg::KIND_INSERT, m, rand_value(style),
                             rand_value($urandom_range(2, 3)),
                             rand_value($urandom_range(0, 3))));
        end
        for (k = 0; k < samples; k++)
            add_req(make_req(ktls_pkg::KIND_SAMPLE, rand_moment(span + span / 4),
                             $urandom, $urandom, $urandom));
    endtask

    task automatic queue_random_phase(int items);
        int n;
        int kk;
        n = 0;
        while (n < items) begin
            // reset is not asserted again, so keep sampling the full table
            kk = $urandom_range(1, 6);
            queue_track_session(kk, $urandom_range(2, 8), $urandom_range(16, 1 << 20));
            n += kk + 5;
        end
    endtask

    initial
    begin
        int k;
        int phase;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty, single key, extremes, zero interval, extrapolation
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0));
        add_req(make_req(ktls_pkg::KIND_INSERT, 32'h0001_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_req(make_req(ktls_pkg::KIND_INSERT, 32'h0002_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'hFFFF_FFFF));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h0001_8000, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h0, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_INSERT, 32'h0002_0000, 32'h1234_5678,
                         32'h0, 32'h0001_0000));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h0002_0000, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h0001_4000, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0003,
                         32'hFFFF_FFFD, 32'h7FFF_FFFF));
        add_req(make_req(ktls_pkg::KIND_INSERT, 32'h0, 32'h0, 32'h0, 32'h0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h8000_0000, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'h0000_0001, 0, 0, 0));
        add_req(make_req(ktls_pkg::KIND_SAMPLE, 32'hFFFF_FFFE, 0, 0, 0));
        wait_drained();

        // fill the table, then overflow it and hold off the receiver meanwhile
        for (k = 0; k < ktls_pkg::MAX_KEYS - 6 + 3; k++)
            add_req(make_req(ktls_pkg::KIND_INSERT, $urandom, $urandom,
                             $urandom, $urandom));
        for (k = 0; k < 4; k++)
            add_req(make_req(ktls_pkg::KIND_SAMPLE, $urandom, 0, 0, 0));
        hold_seq = hold_seq + 1;
        wait_drained();

        // table is full from here; samples walk the full table
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (k = 0; k < 165; k++) begin
                if ($urandom_range(0, 5) == 0)
                    add_req(make_req(ktls_pkg::KIND_INSERT, $urandom, $urandom,
                                     $urandom, $urandom));
                else if ($urandom_range(0, 1) == 0)
                    add_req(make_req(ktls_pkg::KIND_SAMPLE,
                                     trk_time[$urandom_range(0, ktls_pkg::MAX_KEYS - 1)]
                                     + 32'($urandom_range(0, 2)) - 1, 0, 0, 0));
                else
                    add_req(make_req(ktls_pkg::KIND_SAMPLE, $urandom, $urandom,
                                     $urandom, $urandom));
            end
            wait_drained();
        end
        queue_random_phase(100);
        wait_drained();
        repeat (400) @(posedge clk);

        $display("sent %0d requests, checked %0d results", sent_count, checked_count);
        $display("lerp %0d, zero interval %0d, empty %0d, dropped full %0d",
                 sample_count, zero_count, empty_count, full_count);
        if (errors == 0 && expected_samples.size() == 0)
            $display("tb_keyframe_track_lerp_sampler_unit: PASS");
        else
            $display("tb_keyframe_track_lerp_sampler_unit: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_keyframe_track_lerp_sampler_unit: FAIL");
        $finish;
    end
endmodule
